FILE: src/dgd_pkg.sv
// ----------------------------------------------------------------------------
// dgd_pkg
// Shared types, constants and the run-push helper function of the telemetry frame decoder.
// ----------------------------------------------------------------------------
package dgd_pkg;

  // Width of the capture timer; edge gaps wrap at this width.
  localparam int unsigned TIMESTAMP_BITS = 32;

  localparam int unsigned FRAME_BITS   = 21;
  localparam int unsigned CELL_TICKS   = 16;
  localparam int unsigned CELL_SHIFT   = $clog2(CELL_TICKS);
  localparam int unsigned TOTAL_SAT    = 22;
  localparam int unsigned TOTAL_BITS   = 5;
  localparam int unsigned RUN_BITS     = 5;
  localparam int unsigned ERPM_SCALE   = 1000000 * 60 / 100;
  localparam int unsigned ERPM_BITS    = 20;
  localparam int unsigned PERIOD_BITS  = 16;
  localparam int unsigned DIV_STEPS    = ERPM_BITS;
  localparam int unsigned STEP_BITS    = $clog2(DIV_STEPS);
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [11:0] STOPPED_CODE = 12'h0fff;
  localparam logic [3:0]  CHECK_OK     = 4'hf;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BITCOUNT = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;
  localparam logic [1:0] ST_ZEROPER  = 2'd3;

  localparam logic [3:0] GCR_TABLE [32] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd9, 4'd10, 4'd11, 4'd0, 4'd13, 4'd14, 4'd15,
    4'd0, 4'd0, 4'd2, 4'd3, 4'd0, 4'd5, 4'd6, 4'd7,
    4'd0, 4'd0, 4'd8, 4'd1, 4'd0, 4'd4, 4'd12, 4'd0
  };

  typedef logic [TIMESTAMP_BITS-1:0] stamp_t;
  typedef logic [RUN_BITS-1:0]       run_t;

  // One collected frame: the NRZI-decoded bits and how many were gathered.
  typedef struct packed {
    logic [FRAME_BITS-1:0] shift;
    logic [TOTAL_BITS-1:0] total;
  } frame_t;

  // Push a run of len cells: a one followed by len-1 zeros.
  function automatic frame_t push_run(frame_t f, run_t len);
    frame_t r;
    logic [TOTAL_BITS:0] sum;
    r = f;
    sum = {1'b0, f.total} + (TOTAL_BITS + 1)'(len);
    if (len != '0) begin
      if (len >= RUN_BITS'(FRAME_BITS)) begin
        r.shift = '0;
      end else begin
        r.shift = f.shift << len;
      end
      if (len <= RUN_BITS'(FRAME_BITS)) begin
        r.shift = r.shift | (FRAME_BITS'(1) << (len - RUN_BITS'(1)));
      end
      if (sum > (TOTAL_BITS + 1)'(TOTAL_SAT)) begin
        r.total = TOTAL_BITS'(TOTAL_SAT);
      end else begin
        r.total = sum[TOTAL_BITS-1:0];
      end
    end
    return r;
  endfunction

endpackage

FILE: src/dgd_in_if.sv
// ----------------------------------------------------------------------------
// dgd_in_if
// Edge capture channel: one timer capture per transaction.
// ----------------------------------------------------------------------------
interface dgd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] edge_time;
  logic        last_edge;

  modport source (output valid, output edge_time, output last_edge, input ready);
  modport sink   (input valid, input edge_time, input last_edge, output ready);
endinterface

FILE: src/dgd_out_if.sv
// ----------------------------------------------------------------------------
// dgd_out_if
// Result channel: one decoded frame per transaction.
// ----------------------------------------------------------------------------
interface dgd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [19:0] erpm_value;

  modport source (output valid, output status, output erpm_value, input ready);
  modport sink   (input valid, input status, input erpm_value, output ready);
endinterface

FILE: src/dgd_front.sv
// ----------------------------------------------------------------------------
// dgd_front
// Edge collector: turns edge gaps into runs, builds the 21-bit frame and
// hands each finished frame to the queue.
// ----------------------------------------------------------------------------
module dgd_front (
  input  logic            clk,
  input  logic            rst,
  dgd_in_if.sink          edges,
  output logic            frame_valid,
  input  logic            frame_ready,
  output dgd_pkg::frame_t frame_data
);
  import dgd_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_PUSH = 2'd1;
  localparam logic [1:0] F_PAD  = 2'd2;

  logic [1:0] state;
  stamp_t     previous_edge;
  frame_t     cur;
  logic       frame_started;
  run_t       run_len;
  logic       last;

  stamp_t                      stamp;
  stamp_t                      diff;
  logic [TIMESTAMP_BITS:0]     rounded;
  logic [TIMESTAMP_BITS-CELL_SHIFT:0] cells;
  run_t                        len_sat;
  frame_t                      pushed;
  frame_t                      padded;

  assign stamp   = edges.edge_time[TIMESTAMP_BITS-1:0];
  assign diff    = stamp - previous_edge;
  assign rounded = {1'b0, diff} + (TIMESTAMP_BITS + 1)'(CELL_TICKS / 2);
  assign cells   = rounded[TIMESTAMP_BITS:CELL_SHIFT];
  assign len_sat = (cells > (TIMESTAMP_BITS - CELL_SHIFT + 1)'(TOTAL_SAT))
                   ? RUN_BITS'(TOTAL_SAT) : cells[RUN_BITS-1:0];

  assign pushed = push_run(cur, run_len);

  always_comb begin
    padded = cur;
    if (cur.total < TOTAL_BITS'(FRAME_BITS)) begin
      padded = push_run(cur, RUN_BITS'(FRAME_BITS) - RUN_BITS'(cur.total));
    end
  end

  assign edges.ready = (state == F_IDLE);
  assign frame_valid = (state == F_PAD);
  assign frame_data  = padded;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      previous_edge <= '0;
      cur           <= '0;
      frame_started <= 1'b0;
      run_len       <= '0;
      last          <= 1'b0;
    end else begin
      case (state)
        F_IDLE: begin
          if (edges.valid) begin
            last    <= edges.last_edge;
            run_len <= '0;
            state   <= F_PUSH;
            if (!frame_started) begin
              previous_edge <= stamp;
              frame_started <= 1'b1;
              cur           <= '0;
            end else if (cur.total < TOTAL_BITS'(FRAME_BITS)) begin
              run_len       <= len_sat;
              previous_edge <= stamp;
            end
          end
        end
        F_PUSH: begin
          cur   <= pushed;
          state <= last ? F_PAD : F_IDLE;
        end
        F_PAD: begin
          if (frame_ready) begin
            cur           <= '0;
            previous_edge <= '0;
            frame_started <= 1'b0;
            state         <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/dgd_queue.sv
// ----------------------------------------------------------------------------
// dgd_queue
// Two-entry frame queue between the edge collector and the frame decoder.
// ----------------------------------------------------------------------------
module dgd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  dgd_pkg::frame_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output dgd_pkg::frame_t rd_data
);
  import dgd_pkg::*;

  frame_t                    entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;
  logic                      do_wr;
  logic                      do_rd;

  assign wr_ready = (count != (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (QUEUE_PTR_BITS + 1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (QUEUE_PTR_BITS + 1)'(1);
      end
    end
  end

endmodule

FILE: src/dgd_back.sv
// ----------------------------------------------------------------------------
// dgd_back
// Frame decoder: GCR groups to nibbles, checksum, period, and a bit-serial
// division that gives the rounded eRPM value.
// ----------------------------------------------------------------------------
module dgd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            frame_valid,
  output logic            frame_ready,
  input  dgd_pkg::frame_t frame_data,
  dgd_out_if.source       result
);
  import dgd_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_OUT  = 2'd2;

  logic [1:0]             state;
  logic [1:0]             status;
  logic [ERPM_BITS-1:0]   quo;
  logic [PERIOD_BITS-1:0] rem;
  logic [PERIOD_BITS-1:0] divisor;
  logic [STEP_BITS-1:0]   step;

  logic [15:0]            word;
  logic [3:0]             check;
  logic [11:0]            code;
  logic [PERIOD_BITS-1:0] period;
  logic [1:0]             status_next;
  logic                   run_div;
  logic [PERIOD_BITS:0]   trial;
  logic                   fits;

  assign word = {GCR_TABLE[frame_data.shift[19:15]], GCR_TABLE[frame_data.shift[14:10]],
                 GCR_TABLE[frame_data.shift[9:5]],   GCR_TABLE[frame_data.shift[4:0]]};
  assign check  = word[3:0] ^ word[7:4] ^ word[11:8] ^ word[15:12];
  assign code   = word[15:4];
  assign period = PERIOD_BITS'(code[8:0]) << code[11:9];

  always_comb begin
    status_next = ST_OK;
    run_div     = 1'b0;
    if (frame_data.total != TOTAL_BITS'(FRAME_BITS)) begin
      status_next = ST_BITCOUNT;
    end else if (check != CHECK_OK) begin
      status_next = ST_CHECKSUM;
    end else if (code == STOPPED_CODE) begin
      status_next = ST_OK;
    end else if (period == '0) begin
      status_next = ST_ZEROPER;
    end else begin
      run_div = 1'b1;
    end
  end

  // Restoring division, one quotient bit per cycle; the dividend shifts out
  // of quo while the quotient shifts in.
  assign trial = {rem, quo[ERPM_BITS-1]};
  assign fits  = (trial >= {1'b0, divisor});

  assign frame_ready       = (state == B_IDLE);
  assign result.valid      = (state == B_OUT);
  assign result.status     = status;
  assign result.erpm_value = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      status  <= ST_OK;
      quo     <= '0;
      rem     <= '0;
      divisor <= '0;
      step    <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (frame_valid) begin
            status  <= status_next;
            divisor <= period;
            rem     <= '0;
            step    <= '0;
            if (run_div) begin
              quo   <= ERPM_BITS'(ERPM_SCALE) + ERPM_BITS'(period >> 1);
              state <= B_DIV;
            end else begin
              quo   <= '0;
              state <= B_OUT;
            end
          end
        end
        B_DIV: begin
          rem  <= fits ? PERIOD_BITS'(trial - {1'b0, divisor}) : trial[PERIOD_BITS-1:0];
          quo  <= {quo[ERPM_BITS-2:0], fits};
          step <= step + STEP_BITS'(1);
          if (step == STEP_BITS'(DIV_STEPS - 1)) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (result.ready) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (status != ST_OK)) |-> (quo == '0))
    else $error("error status delivered with a nonzero value");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (quo <= ERPM_BITS'(ERPM_SCALE)))
    else $error("eRPM value above the scale");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> ((divisor != '0) && (status == ST_OK)))
    else $error("division started on a zero period or an error frame");
`endif

endmodule

FILE: src/dshot_gcr_erpm_decoder.sv
// ----------------------------------------------------------------------------
// dshot_gcr_erpm_decoder
// Telemetry frame decoder: edge captures in, status and eRPM value out.
// Each edge transaction is accepted, then its run is pushed, before the next edge is
// taken; after the final edge of a frame the finished frame must also enter the queue.
// Error and stopped frames skip the bit-serial divider; the decoder works on one
// frame while the collector gathers the next.
// Synchronous reset clears all control state.
// ----------------------------------------------------------------------------
module dshot_gcr_erpm_decoder (
  input  logic       clk,
  input  logic       rst,
  dgd_in_if.sink     edges,
  dgd_out_if.source  result
);
  import dgd_pkg::*;

  logic   front_valid;
  logic   front_ready;
  frame_t front_data;
  logic   back_valid;
  logic   back_ready;
  frame_t back_data;

  dgd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .edges       (edges),
    .frame_valid (front_valid),
    .frame_ready (front_ready),
    .frame_data  (front_data)
  );

  dgd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_data),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_data  (back_data)
  );

  dgd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (back_valid),
    .frame_ready (back_ready),
    .frame_data  (back_data),
    .result      (result)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the telemetry frame decoder. A short table of frames
// covers the corner cases. Random GCR-encoded frames, damaged frames and line
// noise follow, under several sender and receiver idling patterns. Each result
// transaction is compared with a predicted status and eRPM value.
// ----------------------------------------------------------------------------
module tb_top;
  import dgd_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] erpm;
  } erpm_result_t;

  typedef struct packed {
    logic [31:0]  stamp;
    logic         last;
    logic         pinned;
    erpm_result_t result;
  } edge_item_t;

  // One directed frame: either raw edge gaps or a word to be GCR-encoded.
  typedef struct packed {
    logic             encoded;
    logic             pad;
    logic [31:0]      base;
    logic [11:0]      word;
    logic [1:0]       n_gaps;
    logic [0:2][31:0] gaps;
    logic             pinned;
    erpm_result_t     result;
  } frame_row_t;

  typedef enum int {FLAW_NONE, FLAW_CHECKSUM, FLAW_RUN, FLAW_TAIL} frame_flaw_e;

  localparam logic [3:0] GCR_TO_NIBBLE [32] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd9, 4'd10, 4'd11, 4'd0, 4'd13, 4'd14, 4'd15,
    4'd0, 4'd0, 4'd2, 4'd3, 4'd0, 4'd5, 4'd6, 4'd7,
    4'd0, 4'd0, 4'd8, 4'd1, 4'd0, 4'd4, 4'd12, 4'd0
  };

  localparam logic [4:0] NIBBLE_TO_GCR [16] = '{
    5'h19, 5'h1b, 5'h12, 5'h13, 5'h1d, 5'h15, 5'h16, 5'h17,
    5'h1a, 5'h09, 5'h0a, 5'h0b, 5'h1e, 5'h0d, 5'h0e, 5'h0f
  };

  localparam frame_row_t DIRECTED_FRAMES [5] = '{
    // A lone edge flagged last: one padded run, all-zero nibbles.
    '{encoded: 1'b0, pad: 1'b0, base: 32'hffff_ffff, word: 12'h000, n_gaps: 2'd0,
      gaps: '{32'd0, 32'd0, 32'd0}, pinned: 1'b1,
      result: '{status: ST_CHECKSUM, erpm: 20'd0}},
    // A wrapping gap far beyond the frame length.
    '{encoded: 1'b0, pad: 1'b0, base: 32'hffff_fff0, word: 12'h000, n_gaps: 2'd1,
      gaps: '{32'h8000_000f, 32'd0, 32'd0}, pinned: 1'b1,
      result: '{status: ST_BITCOUNT, erpm: 20'd0}},
    // One 21-cell run fills the frame, the edges after it are ignored.
    '{encoded: 1'b0, pad: 1'b0, base: 32'h0000_0000, word: 12'h000, n_gaps: 2'd3,
      gaps: '{32'd336, 32'd164, 32'd500}, pinned: 1'b1,
      result: '{status: ST_CHECKSUM, erpm: 20'd0}},
    // Gaps of 3 and 7 ticks round to zero cells and push nothing; the 80-tick gap is a 5-cell run.
    '{encoded: 1'b0, pad: 1'b0, base: 32'h1234_5678, word: 12'h000, n_gaps: 2'd3,
      gaps: '{32'd3, 32'd80, 32'd7}, pinned: 1'b0,
      result: '{status: ST_OK, erpm: 20'd0}},
    // Period of one tick gives the top speed.
    '{encoded: 1'b1, pad: 1'b1, base: 32'hffff_ff00, word: 12'h001, n_gaps: 2'd0,
      gaps: '{32'd0, 32'd0, 32'd0}, pinned: 1'b1,
      result: '{status: ST_OK, erpm: 20'd600000}}
  };

  logic clk;
  logic rst;

  dgd_in_if  edge_if ();
  dgd_out_if erpm_if ();

  dshot_gcr_erpm_decoder i_dut (
    .clk    (clk),
    .rst    (rst),
    .edges  (edge_if),
    .result (erpm_if)
  );

  edge_item_t   edge_q [$];
  edge_item_t   shown_edge;
  erpm_result_t expected_erpm_q [$];
  int unsigned  items_queued = 0;
  int unsigned  edges_accepted = 0;
  int unsigned  mismatches = 0;
  int unsigned  send_idle_pct = 35;
  int unsigned  recv_idle_pct = 76;

  // Predictor state for the frame being collected.
  logic [31:0]  last_stamp = '0;
  logic [20:0]  run_bits = '0;
  int unsigned  bits_seen = 0;
  bit           in_frame = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic push_edge(input logic [31:0] stamp, input bit last, input bit pinned,
                           input erpm_result_t result);
    edge_q.push_back('{stamp: stamp, last: last, pinned: pinned, result: result});
    items_queued++;
  endtask

  // A run of len cells enters as a one followed by len-1 zeros.
  task automatic shift_in_run(input int unsigned len);
    if (len == 0) return;
    if (len >= FRAME_BITS) begin
      run_bits = '0;
    end else begin
      run_bits = run_bits << len;
    end
    if (len <= FRAME_BITS) run_bits[len - 1] = 1'b1;
    bits_seen += len;
    if (bits_seen > TOTAL_SAT) bits_seen = TOTAL_SAT;
  endtask

  function automatic erpm_result_t decode_frame(input logic [20:0] bits, input int unsigned total);
    erpm_result_t r;
    logic [15:0]  d;
    logic [11:0]  word;
    logic [15:0]  period;
    int unsigned  speed;
    r = '{status: ST_OK, erpm: 20'd0};
    if (total != FRAME_BITS) begin
      r.status = ST_BITCOUNT;
      return r;
    end
    for (int g = 0; g < 4; g++) d[4*g +: 4] = GCR_TO_NIBBLE[bits[5*g +: 5]];
    if ((d[3:0] ^ d[7:4] ^ d[11:8] ^ d[15:12]) != 4'hf) begin
      r.status = ST_CHECKSUM;
      return r;
    end
    word = d[15:4];
    if (word == 12'hfff) return r;
    period = 16'(word[8:0]) << word[11:9];
    if (period == 16'd0) begin
      r.status = ST_ZEROPER;
      return r;
    end
    speed = (ERPM_SCALE + period / 2) / period;
    r.erpm = 20'(speed);
    return r;
  endfunction

  task automatic track_edge(input edge_item_t it);
    logic [31:0]       gap;
    longint unsigned   len;
    erpm_result_t      r;
    edges_accepted++;
    if (!in_frame) begin
      last_stamp = it.stamp;
      in_frame = 1'b1;
      run_bits = '0;
      bits_seen = 0;
    end else if (bits_seen < FRAME_BITS) begin
      gap = it.stamp - last_stamp;
      len = (64'(gap) + CELL_TICKS / 2) / CELL_TICKS;
      if (len > TOTAL_SAT) len = TOTAL_SAT;
      shift_in_run(32'(len));
      last_stamp = it.stamp;
    end
    if (!it.last) return;
    if (bits_seen < FRAME_BITS) shift_in_run(FRAME_BITS - bits_seen);
    r = decode_frame(run_bits, bits_seen);
    if (it.pinned) r = it.result;
    expected_erpm_q.push_back(r);
    in_frame = 1'b0;
    last_stamp = '0;
    run_bits = '0;
    bits_seen = 0;
  endtask

  // Queue the edges of a GCR frame carrying word, optionally damaged.
  task automatic queue_gcr_frame(input logic [31:0] base, input logic [11:0] word,
                                 input bit pad, input int jit, input frame_flaw_e flaw,
                                 input erpm_result_t result, input bit pinned);
    logic [3:0]  nib [4];
    logic [20:0] pattern;
    logic [31:0] stamp;
    int          runs [$];
    int          len;
    int          cum;
    int          n_edges;
    int          pick;
    int          n_extra;
    nib[3] = word[11:8];
    nib[2] = word[7:4];
    nib[1] = word[3:0];
    nib[0] = ~(nib[1] ^ nib[2] ^ nib[3]);
    if (flaw == FLAW_CHECKSUM) nib[0] = nib[0] ^ 4'($urandom_range(15, 1));
    pattern[20] = 1'b1;
    for (int g = 0; g < 4; g++) pattern[5*g +: 5] = NIBBLE_TO_GCR[nib[g]];
    len = 1;
    for (int k = 19; k >= 0; k--) begin
      if (pattern[k]) begin
        runs.push_back(len);
        len = 1;
      end else begin
        len++;
      end
    end
    runs.push_back(len);
    if (flaw == FLAW_RUN) begin
      pick = $urandom_range(runs.size() - 1);
      if (runs[pick] > 1 && $urandom_range(1) == 1) begin
        runs[pick]--;
      end else begin
        runs[pick] += $urandom_range(3, 1);
      end
    end
    if (flaw == FLAW_TAIL) pad = 1'b0;
    // With padding the decoder supplies the final run on its own.
    n_edges = pad ? runs.size() : runs.size() + 1;
    cum = 0;
    for (int k = 0; k < n_edges; k++) begin
      if (k != 0) cum += runs[k - 1];
      stamp = base + 32'(16 * cum + int'($urandom_range(2 * jit)) - jit);
      push_edge(stamp, k == n_edges - 1 && flaw != FLAW_TAIL, pinned && k == n_edges - 1,
                result);
    end
    if (flaw == FLAW_TAIL) begin
      n_extra = $urandom_range(3, 1);
      for (int k = 0; k < n_extra; k++) begin
        stamp += $urandom_range(400);
        push_edge(stamp, k == n_extra - 1, 1'b0, '0);
      end
    end
  endtask

  task automatic wait_drained();
    while (edges_accepted != items_queued || expected_erpm_q.size() != 0) @(posedge clk);
  endtask

  // Edge sender and input monitor.
  always @(posedge clk) begin
    if (rst) begin
      edge_if.valid     <= 1'b0;
      edge_if.edge_time <= '0;
      edge_if.last_edge <= 1'b0;
    end else begin
      if (edge_if.valid && edge_if.ready) track_edge(shown_edge);
      if (!edge_if.valid || edge_if.ready) begin
        if (edge_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          shown_edge = edge_q.pop_front();
          edge_if.valid     <= 1'b1;
          edge_if.edge_time <= shown_edge.stamp;
          edge_if.last_edge <= shown_edge.last;
        end else begin
          edge_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver and checker.
  always @(posedge clk) begin
    erpm_result_t want;
    if (rst) begin
      erpm_if.ready <= 1'b0;
    end else begin
      if (erpm_if.valid && erpm_if.ready) begin
        if (expected_erpm_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result transaction: status %0d erpm %0d",
                     erpm_if.status, erpm_if.erpm_value);
          end
        end else begin
          want = expected_erpm_q.pop_front();
          if (erpm_if.status !== want.status || erpm_if.erpm_value !== want.erpm) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result differs: expected status %0d erpm %0d, got status %0d erpm %0d",
                       want.status, want.erpm, erpm_if.status, erpm_if.erpm_value);
            end
          end
        end
      end
      erpm_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    frame_row_t  row;
    logic [31:0] stamp;
    logic [31:0] gap;
    logic [11:0] word;
    frame_flaw_e flaw;
    int unsigned pick;
    int          n;
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_FRAMES[r]) begin
      row = DIRECTED_FRAMES[r];
      if (row.encoded) begin
        queue_gcr_frame(row.base, row.word, row.pad, 0, FLAW_NONE, row.result, row.pinned);
      end else begin
        stamp = row.base;
        for (int k = 0; k <= row.n_gaps; k++) begin
          if (k != 0) stamp += row.gaps[k - 1];
          push_edge(stamp, k == row.n_gaps, row.pinned && k == row.n_gaps, row.result);
        end
      end
    end
    // Hold the sender until the decoder has emptied completely.
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (items_queued < 25 + 650 * (phase + 1)) begin
        pick = $urandom_range(99);
        if (pick < 78) begin
          case ($urandom_range(9))
            0: word = 12'hfff;
            1: word = {3'($urandom), 9'h000};
            2: word = {3'h0, 9'($urandom_range(3, 1))};
            3: word = {3'h7, 9'($urandom)};
            default: word = 12'($urandom);
          endcase
          if (pick < 55) begin
            flaw = FLAW_NONE;
          end else if (pick < 63) begin
            flaw = FLAW_CHECKSUM;
          end else if (pick < 70) begin
            flaw = FLAW_RUN;
          end else begin
            flaw = FLAW_TAIL;
          end
          queue_gcr_frame($urandom(), word, 1'($urandom_range(1)), $urandom_range(3), flaw,
                          '0, 1'b0);
        end else begin
          // Line noise: arbitrary gaps, from sub-cell glitches to huge jumps.
          n = $urandom_range(30, 1);
          stamp = $urandom();
          for (int k = 0; k < n; k++) begin
            if (k != 0) begin
              case ($urandom_range(3))
                0: gap = $urandom_range(40);
                1: gap = $urandom_range(16 * 24 + 15);
                2: gap = $urandom();
                default: gap = 16 * $urandom_range(3, 1) + $urandom_range(14) - 7;
              endcase
              stamp += gap;
            end
            push_edge(stamp, k == n - 1, 1'b0, '0);
          end
        end
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_erpm_q.size() == 0) begin
      $display("dshot_gcr_erpm_decoder: match");
    end else begin
      $display("dshot_gcr_erpm_decoder: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("dshot_gcr_erpm_decoder: mismatch");
    $finish;
  end

endmodule
